[hdl/svm_pkg.sv]
// Shared types and constants for the script instruction execute core.
// Holds opcodes, fault and condition codes, and the structs between modules.
// Depends on nothing; the design modules use it by scoped names and the testbench imports it.
package svm_pkg;

	// Widths fixed by the instruction format.
	localparam int unsigned DATA_W    = 16;
	localparam int unsigned VAR_COUNT = 256;
	localparam int unsigned VAR_AW    = 8;

	// Compare byte layout: bit 7 selects the variable operand.
	localparam int unsigned CMP_VAR_BIT = 7;

	// Offset reported by kill.
	localparam logic [DATA_W-1:0] KILL_PC = 16'hFFFF;

	// Instruction codes.
	typedef enum logic [7:0] {
		OP_MOVI = 8'h00,
		OP_MOVW = 8'h01,
		OP_ADDW = 8'h02,
		OP_ADDI = 8'h03,
		OP_CALL = 8'h04,
		OP_RET  = 8'h05,
		OP_YLD  = 8'h06,
		OP_JMP  = 8'h07,
		OP_JNZ  = 8'h09,
		OP_CJMP = 8'h0A,
		OP_KILL = 8'h11,
		OP_SUBW = 8'h13,
		OP_ANDI = 8'h14,
		OP_IORI = 8'h15,
		OP_SHLI = 8'h16,
		OP_SHRI = 8'h17
	} op_t;

	// Fault codes on the result.
	typedef enum logic [1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_OVERFLOW  = 2'd1,
		FAULT_UNDERFLOW = 2'd2,
		FAULT_OPCODE    = 2'd3
	} fault_t;

	// Compare conditions; the two remaining codes never branch.
	typedef enum logic [2:0] {
		COND_EQ = 3'd0,
		COND_NE = 3'd1,
		COND_GT = 3'd2,
		COND_GE = 3'd3,
		COND_LT = 3'd4,
		COND_LE = 3'd5
	} cond_t;

	// One decoded instruction as held in the execute stage.
	typedef struct packed {
		logic [7:0]        opcode;
		logic [VAR_AW-1:0] dst_index;
		logic [VAR_AW-1:0] src_index;
		logic [DATA_W-1:0] immediate;
		logic [7:0]        compare_mode;
		logic [DATA_W-1:0] target_pc;
		logic [DATA_W-1:0] fallthrough_pc;
		logic              new_slice;
	} instr_t;

	// One result item.
	typedef struct packed {
		logic [DATA_W-1:0]        next_pc;
		logic                     yield_now;
		fault_t                   fault_code;
		logic                     branch_taken;
		logic                     wrote_variable;
		logic signed [DATA_W-1:0] written_value;
	} res_t;

	// Stack status seen by the execute logic.
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [DATA_W-1:0] top;
	} stack_stat_t;

	// Stack update requested by the execute logic.
	typedef struct packed {
		logic push;
		logic pop;
	} stack_req_t;

	typedef struct packed {
		res_t       res;
		stack_req_t stk;
	} exec_out_t;

endpackage

[hdl/svm_in_if.sv]
// Instruction channel: valid/ready handshake with the decoded instruction fields.
// Depends on nothing.
interface svm_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  opcode;
	logic [7:0]  dst_index;
	logic [7:0]  src_index;
	logic [15:0] immediate;
	logic [7:0]  compare_mode;
	logic [15:0] target_pc;
	logic [15:0] fallthrough_pc;
	logic        new_slice;

	modport source (
		output valid, opcode, dst_index, src_index, immediate, compare_mode,
			target_pc, fallthrough_pc, new_slice,
		input  ready
	);

	modport sink (
		input  valid, opcode, dst_index, src_index, immediate, compare_mode,
			target_pc, fallthrough_pc, new_slice,
		output ready
	);
endinterface

[hdl/svm_out_if.sv]
// Result channel: valid/ready handshake with the execution result fields.
// Depends on nothing.
interface svm_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        next_pc;
	logic               yield_now;
	logic [1:0]         fault_code;
	logic               branch_taken;
	logic               wrote_variable;
	logic signed [15:0] written_value;

	modport source (
		output valid, next_pc, yield_now, fault_code, branch_taken, wrote_variable,
			written_value,
		input  ready
	);

	modport sink (
		input  valid, next_pc, yield_now, fault_code, branch_taken, wrote_variable,
			written_value,
		output ready
	);
endinterface

[hdl/svm_var_file.sv]
// Variable file: 256 x 16 memory with two registered read ports and one write port.
// Per-entry valid bits make unwritten entries read as zero; a one-deep bypass covers
// a write landing on the same edge as a read. Depends on svm_pkg.
module svm_var_file (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [svm_pkg::VAR_AW-1:0]        rd_dst_addr,
	input  logic [svm_pkg::VAR_AW-1:0]        rd_src_addr,
	input  logic                              wr_en,
	input  logic [svm_pkg::VAR_AW-1:0]        wr_addr,
	input  logic [svm_pkg::DATA_W-1:0]        wr_data,
	output logic [svm_pkg::DATA_W-1:0]        dst_data,
	output logic [svm_pkg::DATA_W-1:0]        src_data
);

	logic [svm_pkg::DATA_W-1:0]    mem [svm_pkg::VAR_COUNT];
	logic [svm_pkg::VAR_COUNT-1:0] written_q;
	logic [svm_pkg::DATA_W-1:0]    rd_dst_q;
	logic [svm_pkg::DATA_W-1:0]    rd_src_q;
	logic [svm_pkg::DATA_W-1:0]    byp_val_q;
	logic                          dst_seen_q;
	logic                          src_seen_q;
	logic                          dst_byp_q;
	logic                          src_byp_q;

	// Memory write and registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_dst_q  <= mem[rd_dst_addr];
			rd_src_q  <= mem[rd_src_addr];
			byp_val_q <= wr_data;
		end
	end

	// Written marks, cleared at reset so the file reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// Read-side flags: entry written before, or written on the read edge itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_seen_q <= 1'b0;
			src_seen_q <= 1'b0;
			dst_byp_q  <= 1'b0;
			src_byp_q  <= 1'b0;
		end else if (rd_en) begin
			dst_seen_q <= written_q[rd_dst_addr];
			src_seen_q <= written_q[rd_src_addr];
			dst_byp_q  <= wr_en && (wr_addr == rd_dst_addr);
			src_byp_q  <= wr_en && (wr_addr == rd_src_addr);
		end
	end

	// Resolve read data.
	assign dst_data = dst_byp_q ? byp_val_q : (dst_seen_q ? rd_dst_q : '0);
	assign src_data = src_byp_q ? byp_val_q : (src_seen_q ? rd_src_q : '0);

endmodule

[hdl/svm_ret_stack.sv]
// Return stack: memory of return offsets plus the stack level register.
// The top entry is read ahead at instruction acceptance, with a bypass for a push
// on the same edge. Depends on svm_pkg.
module svm_ret_stack #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic                        adv,
	input  logic                        new_slice,
	input  svm_pkg::stack_req_t         req,
	input  logic [svm_pkg::DATA_W-1:0]  push_data,
	output svm_pkg::stack_stat_t        stat
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

	logic [svm_pkg::DATA_W-1:0] mem [STACK_DEPTH];
	logic [LW-1:0]              level_q;
	logic [LW-1:0]              eff_level;
	logic [LW-1:0]              level_next;
	logic [LW-1:0]              rd_level;
	logic [svm_pkg::DATA_W-1:0] rd_q;
	logic [svm_pkg::DATA_W-1:0] byp_val_q;
	logic                       byp_q;

	// Level seen by the item in execute, after a new slice clears it.
	assign eff_level = new_slice ? '0 : level_q;

	// Level after the item in execute retires.
	always_comb begin
		level_next = level_q;
		if (adv) begin
			if (req.push) begin
				level_next = eff_level + LW'(1);
			end else if (req.pop) begin
				level_next = eff_level - LW'(1);
			end else begin
				level_next = eff_level;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= level_next;
		end
	end

	// Top entry address for the next item.
	assign rd_level = level_next - LW'(1);

	// Push write and read-ahead of the top entry.
	always_ff @(posedge clk) begin
		if (adv && req.push) begin
			mem[eff_level[AW-1:0]] <= push_data;
		end
		if (rd_en) begin
			rd_q      <= mem[rd_level[AW-1:0]];
			byp_val_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= adv && req.push;
		end
	end

	// Status for the execute logic.
	assign stat.full  = (eff_level == LW'(STACK_DEPTH));
	assign stat.empty = (eff_level == '0);
	assign stat.top   = byp_q ? byp_val_q : rd_q;

	// The level never passes the stack depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("return stack level beyond depth");

endmodule

[hdl/svm_exec.sv]
// Execute logic: one instruction's data result, next offset, fault and stack request.
// Purely combinational between the execute-stage register and the result register.
// Depends on svm_pkg.
module svm_exec (
	input  svm_pkg::instr_t             ins,
	input  logic [svm_pkg::DATA_W-1:0]  dst_val,
	input  logic [svm_pkg::DATA_W-1:0]  src_val,
	input  svm_pkg::stack_stat_t        stat,
	output svm_pkg::exec_out_t          ex
);

	logic [svm_pkg::DATA_W-1:0] cmp_b;
	logic [svm_pkg::DATA_W-1:0] dec_val;
	logic                       shift_big;
	logic                       cond_hit;

	assign cmp_b     = ins.compare_mode[svm_pkg::CMP_VAR_BIT] ? src_val : ins.immediate;
	assign dec_val   = dst_val - svm_pkg::DATA_W'(1);
	assign shift_big = |ins.immediate[svm_pkg::DATA_W-1:4];

	// Signed compare of the tested variable against the second operand.
	always_comb begin
		case (svm_pkg::cond_t'(ins.compare_mode[2:0]))
			svm_pkg::COND_EQ: cond_hit = (dst_val == cmp_b);
			svm_pkg::COND_NE: cond_hit = (dst_val != cmp_b);
			svm_pkg::COND_GT: cond_hit = ($signed(dst_val) >  $signed(cmp_b));
			svm_pkg::COND_GE: cond_hit = ($signed(dst_val) >= $signed(cmp_b));
			svm_pkg::COND_LT: cond_hit = ($signed(dst_val) <  $signed(cmp_b));
			svm_pkg::COND_LE: cond_hit = ($signed(dst_val) <= $signed(cmp_b));
			default:          cond_hit = 1'b0;
		endcase
	end

	// Operation select.
	always_comb begin
		ex.res.next_pc        = ins.fallthrough_pc;
		ex.res.yield_now      = 1'b0;
		ex.res.fault_code     = svm_pkg::FAULT_NONE;
		ex.res.branch_taken   = 1'b0;
		ex.res.wrote_variable = 1'b0;
		ex.res.written_value  = '0;
		ex.stk.push           = 1'b0;
		ex.stk.pop            = 1'b0;
		case (svm_pkg::op_t'(ins.opcode))
			svm_pkg::OP_MOVI: begin
				ex.res.written_value  = ins.immediate;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_MOVW: begin
				ex.res.written_value  = src_val;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_ADDW: begin
				ex.res.written_value  = dst_val + src_val;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_ADDI: begin
				ex.res.written_value  = dst_val + ins.immediate;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_CALL: begin
				if (stat.full) begin
					ex.res.fault_code = svm_pkg::FAULT_OVERFLOW;
				end else begin
					ex.stk.push         = 1'b1;
					ex.res.next_pc      = ins.target_pc;
					ex.res.branch_taken = 1'b1;
				end
			end
			svm_pkg::OP_RET: begin
				if (stat.empty) begin
					ex.res.fault_code = svm_pkg::FAULT_UNDERFLOW;
				end else begin
					ex.stk.pop          = 1'b1;
					ex.res.next_pc      = stat.top;
					ex.res.branch_taken = 1'b1;
				end
			end
			svm_pkg::OP_YLD: begin
				ex.res.yield_now = 1'b1;
			end
			svm_pkg::OP_JMP: begin
				ex.res.next_pc      = ins.target_pc;
				ex.res.branch_taken = 1'b1;
			end
			svm_pkg::OP_JNZ: begin
				ex.res.written_value  = dec_val;
				ex.res.wrote_variable = 1'b1;
				if (dec_val != '0) begin
					ex.res.next_pc      = ins.target_pc;
					ex.res.branch_taken = 1'b1;
				end
			end
			svm_pkg::OP_CJMP: begin
				if (cond_hit) begin
					ex.res.next_pc      = ins.target_pc;
					ex.res.branch_taken = 1'b1;
				end
			end
			svm_pkg::OP_KILL: begin
				ex.res.next_pc   = svm_pkg::KILL_PC;
				ex.res.yield_now = 1'b1;
			end
			svm_pkg::OP_SUBW: begin
				ex.res.written_value  = dst_val - src_val;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_ANDI: begin
				ex.res.written_value  = dst_val & ins.immediate;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_IORI: begin
				ex.res.written_value  = dst_val | ins.immediate;
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_SHLI: begin
				ex.res.written_value  = shift_big ? '0 : (dst_val << ins.immediate[3:0]);
				ex.res.wrote_variable = 1'b1;
			end
			svm_pkg::OP_SHRI: begin
				ex.res.written_value  = shift_big ? '0 : (dst_val >> ins.immediate[3:0]);
				ex.res.wrote_variable = 1'b1;
			end
			default: begin
				ex.res.fault_code = svm_pkg::FAULT_OPCODE;
			end
		endcase
	end

endmodule

[hdl/script_vm_execute_core.sv]
// Top level of the script instruction execute core: handshake, stage registers,
// variable file, return stack and execute logic.
// Depends on svm_pkg, svm_in_if, svm_out_if, svm_var_file, svm_ret_stack, svm_exec.
//
//   Channel   Modport   Carries
//   instr     sink      one decoded instruction per item
//   result    source    next offset, yield, fault, branch and written value per item
//
// One item is accepted per cycle while the result side keeps taking results; its result
// passes through the stage 1 register and then the result register before it turns valid.
// Stage 1 holds the instruction while the variable file's registered read ports
// deliver its operands; the result register follows and decouples the two sides.
// Reset clears the valid marks of the variable file at once, so no clearing pass runs.
// A stalled result holds stage 1, and instr.ready drops only when both stages are full.
module script_vm_execute_core #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	svm_in_if.sink    instr,
	svm_out_if.source result
);

	logic                       accept;
	logic                       adv;
	logic                       valid_s1;
	svm_pkg::instr_t            ins_s1;
	logic                       valid_s2;
	svm_pkg::res_t              res_s2;
	logic [svm_pkg::DATA_W-1:0] dst_val;
	logic [svm_pkg::DATA_W-1:0] src_val;
	svm_pkg::stack_stat_t       stat;
	svm_pkg::exec_out_t         ex;

	// Handshake and stage advance.
	assign adv         = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready = !valid_s1 || adv;
	assign accept      = instr.valid && instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Stage 1 instruction register and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1.opcode         <= instr.opcode;
			ins_s1.dst_index      <= instr.dst_index;
			ins_s1.src_index      <= instr.src_index;
			ins_s1.immediate      <= instr.immediate;
			ins_s1.compare_mode   <= instr.compare_mode;
			ins_s1.target_pc      <= instr.target_pc;
			ins_s1.fallthrough_pc <= instr.fallthrough_pc;
			ins_s1.new_slice      <= instr.new_slice;
		end
		if (adv) begin
			res_s2 <= ex.res;
		end
	end

	// Variable file, read at acceptance and written when the item retires.
	svm_var_file u_var_file (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (accept),
		.rd_dst_addr (instr.dst_index),
		.rd_src_addr (instr.src_index),
		.wr_en       (adv && ex.res.wrote_variable),
		.wr_addr     (ins_s1.dst_index),
		.wr_data     (ex.res.written_value),
		.dst_data    (dst_val),
		.src_data    (src_val)
	);

	// Return stack.
	svm_ret_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_ret_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.adv       (adv),
		.new_slice (ins_s1.new_slice),
		.req       (ex.stk),
		.push_data (ins_s1.fallthrough_pc),
		.stat      (stat)
	);

	// Execute logic.
	svm_exec u_exec (
		.ins     (ins_s1),
		.dst_val (dst_val),
		.src_val (src_val),
		.stat    (stat),
		.ex      (ex)
	);

	// Result port.
	assign result.valid          = valid_s2;
	assign result.next_pc        = res_s2.next_pc;
	assign result.yield_now      = res_s2.yield_now;
	assign result.fault_code     = res_s2.fault_code;
	assign result.branch_taken   = res_s2.branch_taken;
	assign result.wrote_variable = res_s2.wrote_variable;
	assign result.written_value  = res_s2.written_value;

	// A faulting item never branches and never writes a variable.
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.fault_code != svm_pkg::FAULT_NONE))
			|-> (!res_s2.branch_taken && !res_s2.wrote_variable))
		else $error("faulting item branched or wrote a variable");

	// No write means a zero written value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.wrote_variable) |-> (res_s2.written_value == '0))
		else $error("written value nonzero without a write");

	// An instruction held in stage 1 keeps its fields until it retires.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(ins_s1)))
		else $error("stage 1 instruction changed while stalled");

endmodule

[dv/svm_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the script execute core testbench: its own copy of the variable
// file, return stack and stack level, and an in-order store of predicted results.
// Depends on svm_pkg for the opcode, fault, condition and result types.
package svm_tb_pkg;
	import svm_pkg::*;

	class svm_exec_scoreboard;
		logic [DATA_W-1:0] vars [VAR_COUNT];
		logic [DATA_W-1:0] ret_stack [];
		int unsigned       stack_depth;
		int unsigned       level;
		int unsigned       max_level;
		res_t              pending_results [$];
		int unsigned       checked;
		int unsigned       mismatches;
		int unsigned       overflows;
		int unsigned       underflows;
		int unsigned       bad_opcodes;

		function new(int unsigned depth);
			stack_depth = depth;
			ret_stack   = new[depth];
			foreach (vars[i])
				vars[i] = '0;
			level       = 0;
			max_level   = 0;
			checked     = 0;
			mismatches  = 0;
			overflows   = 0;
			underflows  = 0;
			bad_opcodes = 0;
		endfunction

		// Signed compare of the tested variable against the second operand.
		function bit cond_met(logic [2:0] code, logic signed [DATA_W-1:0] lhs,
				logic signed [DATA_W-1:0] rhs);
			case (code)
			COND_EQ: return lhs == rhs;
			COND_NE: return lhs != rhs;
			COND_GT: return lhs > rhs;
			COND_GE: return lhs >= rhs;
			COND_LT: return lhs < rhs;
			COND_LE: return lhs <= rhs;
			default: return 1'b0;
			endcase
		endfunction

		// Executes one accepted instruction and queues the result it must produce.
		function void note_instr(instr_t it);
			logic [DATA_W-1:0] d;
			logic [DATA_W-1:0] s;
			logic [DATA_W-1:0] rhs;
			logic [DATA_W-1:0] value;
			bit                wrote;
			res_t              r;

			if (it.new_slice)
				level = 0;
			d     = vars[it.dst_index];
			s     = vars[it.src_index];
			value = '0;
			wrote = 1'b0;
			r.next_pc      = it.fallthrough_pc;
			r.yield_now    = 1'b0;
			r.fault_code   = FAULT_NONE;
			r.branch_taken = 1'b0;

			case (it.opcode)
			OP_MOVI: begin value = it.immediate;     wrote = 1'b1; end
			OP_MOVW: begin value = s;                wrote = 1'b1; end
			OP_ADDW: begin value = d + s;            wrote = 1'b1; end
			OP_ADDI: begin value = d + it.immediate; wrote = 1'b1; end
			OP_SUBW: begin value = d - s;            wrote = 1'b1; end
			OP_ANDI: begin value = d & it.immediate; wrote = 1'b1; end
			OP_IORI: begin value = d | it.immediate; wrote = 1'b1; end
			OP_SHLI: begin
				value = (it.immediate >= 16) ? '0 : d << it.immediate[3:0];
				wrote = 1'b1;
			end
			OP_SHRI: begin
				value = (it.immediate >= 16) ? '0 : d >> it.immediate[3:0];
				wrote = 1'b1;
			end
			OP_CALL: begin
				// A full stack faults and leaves both the stack and the flow alone.
				if (level >= stack_depth) begin
					r.fault_code = FAULT_OVERFLOW;
					overflows++;
				end else begin
					ret_stack[level] = it.fallthrough_pc;
					level++;
					if (level > max_level)
						max_level = level;
					r.next_pc      = it.target_pc;
					r.branch_taken = 1'b1;
				end
			end
			OP_RET: begin
				if (level == 0) begin
					r.fault_code = FAULT_UNDERFLOW;
					underflows++;
				end else begin
					level--;
					r.next_pc      = ret_stack[level];
					r.branch_taken = 1'b1;
				end
			end
			OP_YLD: r.yield_now = 1'b1;
			OP_JMP: begin
				r.next_pc      = it.target_pc;
				r.branch_taken = 1'b1;
			end
			OP_JNZ: begin
				// The decremented value is written back whether or not we branch.
				value = d - 16'd1;
				wrote = 1'b1;
				if (value != '0) begin
					r.next_pc      = it.target_pc;
					r.branch_taken = 1'b1;
				end
			end
			OP_CJMP: begin
				rhs = it.compare_mode[CMP_VAR_BIT] ? s : it.immediate;
				if (cond_met(it.compare_mode[2:0], d, rhs)) begin
					r.next_pc      = it.target_pc;
					r.branch_taken = 1'b1;
				end
			end
			OP_KILL: begin
				r.next_pc   = KILL_PC;
				r.yield_now = 1'b1;
			end
			default: begin
				r.fault_code = FAULT_OPCODE;
				bad_opcodes++;
			end
			endcase

			if (wrote)
				vars[it.dst_index] = value;
			r.wrote_variable = wrote;
			r.written_value  = wrote ? value : '0;
			pending_results.push_back(r);
		endfunction

		function string fmt(res_t r);
			return $sformatf("next_pc %h yield %b fault %0d taken %b wrote %b value %h",
				r.next_pc, r.yield_now, r.fault_code, r.branch_taken, r.wrote_variable,
				r.written_value);
		endfunction

		// Compares one result from the block with the oldest prediction.
		function void check_result(res_t got);
			res_t want;

			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result with no instruction outstanding: %s", fmt(got));
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.next_pc !== want.next_pc || got.yield_now !== want.yield_now ||
					got.fault_code !== want.fault_code ||
					got.branch_taken !== want.branch_taken ||
					got.wrote_variable !== want.wrote_variable ||
					got.written_value !== want.written_value) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Mismatch on result %0d", checked);
					$display("  expected %s", fmt(want));
					$display("  actual   %s", fmt(got));
				end
			end
		endfunction
	endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the script execute core testbench: clock, reset, instruction driver,
// result sink with random stalls, and the directed and random instruction streams.
// Depends on svm_pkg, svm_in_if, svm_out_if, svm_tb_pkg and script_vm_execute_core.
module tb_top;
	import svm_pkg::*;
	import svm_tb_pkg::*;

	localparam int unsigned RET_DEPTH   = 64;
	localparam int unsigned ITEM_TARGET = 1450;

	logic clk;
	logic arst_n;
	bit   no_idle = 1'b0;
	int unsigned sent = 0;

	svm_in_if  instr_bus ();
	svm_out_if result_bus ();

	svm_exec_scoreboard sb = new(RET_DEPTH);

	script_vm_execute_core #(
		.STACK_DEPTH(RET_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.instr (instr_bus),
		.result(result_bus)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit in case the block stops accepting or producing items.
	initial begin
		#8ms;
		$display("[script_vm_execute_core] ERROR");
		$finish;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic bit is_known(logic [7:0] op);
		case (op)
		OP_MOVI, OP_MOVW, OP_ADDW, OP_ADDI, OP_CALL, OP_RET, OP_YLD, OP_JMP,
		OP_JNZ, OP_CJMP, OP_KILL, OP_SUBW, OP_ANDI, OP_IORI, OP_SHLI, OP_SHRI:
			return 1'b1;
		default:
			return 1'b0;
		endcase
	endfunction

	// Indices lean toward a few variables so that results feed later operands.
	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'h0001;
		2: return 16'h7FFF;
		3: return 16'h8000;
		4: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic instr_t mk(logic [7:0] op, logic [7:0] dst, logic [7:0] src,
			logic [15:0] imm, logic [7:0] mode, bit slice);
		instr_t it;
		it.opcode         = op;
		it.dst_index      = dst;
		it.src_index      = src;
		it.immediate      = imm;
		it.compare_mode   = mode;
		it.target_pc      = 16'($urandom);
		it.fallthrough_pc = 16'($urandom);
		it.new_slice      = slice;
		return it;
	endfunction

	// One random instruction; a small share carries an unsupported opcode.
	function automatic instr_t rand_item();
		instr_t it;
		it = mk(8'h00, pick_index(), pick_index(), pick_word(),
			8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
		if ($urandom_range(0, 11) == 0) begin
			do it.opcode = 8'($urandom_range(0, 255)); while (is_known(it.opcode));
		end else begin
			do it.opcode = 8'($urandom_range(0, 8'h17)); while (!is_known(it.opcode));
		end
		case (it.opcode)
		OP_SHLI, OP_SHRI:
			if ($urandom_range(0, 3) != 0)
				it.immediate = 16'($urandom_range(0, 18));
		OP_CJMP: begin
			// Bias toward equal operands so the eq, ge and le edges are hit.
			if ($urandom_range(0, 2) == 0)
				it.immediate = sb.vars[it.dst_index];
			if ($urandom_range(0, 2) == 0)
				it.src_index = it.dst_index;
		end
		default: ;
		endcase
		return it;
	endfunction

	// Work done between calls and returns: anything but stack operations.
	function automatic instr_t body_item();
		instr_t it;
		do it = rand_item(); while (it.opcode == OP_CALL || it.opcode == OP_RET);
		it.new_slice = 1'b0;
		return it;
	endfunction

	// Presents one item and waits until the block takes it.
	task automatic send(instr_t it);
		int unsigned gap;
		gap = no_idle ? 0 : idle_length();
		if (gap != 0) begin
			instr_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_bus.valid          <= 1'b1;
		instr_bus.opcode         <= it.opcode;
		instr_bus.dst_index      <= it.dst_index;
		instr_bus.src_index      <= it.src_index;
		instr_bus.immediate      <= it.immediate;
		instr_bus.compare_mode   <= it.compare_mode;
		instr_bus.target_pc      <= it.target_pc;
		instr_bus.fallthrough_pc <= it.fallthrough_pc;
		instr_bus.new_slice      <= it.new_slice;
		do @(posedge clk); while (!instr_bus.ready);
		sb.note_instr(it);
		sent++;
	endtask

	// Nested calls with work in between, unwound until the stack is empty and
	// sometimes one return further.
	task automatic call_chain(int unsigned depth, bit fresh);
		instr_t it;
		for (int unsigned i = 0; i < depth; i++) begin
			it = rand_item();
			it.opcode    = OP_CALL;
			it.new_slice = fresh && i == 0;
			send(it);
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) send(body_item());
		end
		while (sb.level != 0) begin
			it = rand_item();
			it.opcode    = OP_RET;
			it.new_slice = 1'b0;
			send(it);
			if ($urandom_range(0, 3) == 0)
				send(body_item());
		end
		if ($urandom_range(0, 1) == 0)
			send(mk(OP_RET, pick_index(), pick_index(), pick_word(), 8'h00, 1'b0));
	endtask

	// Result side: check every accepted result, stall at random.
	initial begin
		int unsigned stall;
		res_t        got;
		stall = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got.next_pc        = result_bus.next_pc;
				got.yield_now      = result_bus.yield_now;
				got.fault_code     = fault_t'(result_bus.fault_code);
				got.branch_taken   = result_bus.branch_taken;
				got.wrote_variable = result_bus.wrote_variable;
				got.written_value  = result_bus.written_value;
				sb.check_result(got);
			end
			if (stall != 0) begin
				stall--;
				result_bus.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 25) begin
				stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) :
					$urandom_range(9, 39);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Reset, directed instructions, then random streams, then drain.
	initial begin
		int unsigned r;

		arst_n                   <= 1'b0;
		instr_bus.valid          <= 1'b0;
		instr_bus.opcode         <= '0;
		instr_bus.dst_index      <= '0;
		instr_bus.src_index      <= '0;
		instr_bus.immediate      <= '0;
		instr_bus.compare_mode   <= '0;
		instr_bus.target_pc      <= '0;
		instr_bus.fallthrough_pc <= '0;
		instr_bus.new_slice      <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data operations at the extremes of values, indices and shift amounts.
		send(mk(OP_MOVI, 8'd0,   8'd0,   16'hFFFF, 8'h00, 1'b0));
		send(mk(OP_MOVI, 8'd255, 8'd0,   16'h0001, 8'h00, 1'b0));
		send(mk(OP_ADDW, 8'd0,   8'd255, 16'h0000, 8'h00, 1'b0));
		send(mk(OP_ADDI, 8'd255, 8'd0,   16'hFFFF, 8'h00, 1'b0));
		send(mk(OP_MOVI, 8'd1,   8'd0,   16'h8000, 8'h00, 1'b0));
		send(mk(OP_SUBW, 8'd255, 8'd1,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_MOVW, 8'd2,   8'd1,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_ANDI, 8'd2,   8'd0,   16'hF0F0, 8'h00, 1'b0));
		send(mk(OP_IORI, 8'd2,   8'd0,   16'h00FF, 8'h00, 1'b0));
		send(mk(OP_SHLI, 8'd2,   8'd0,   16'd15,   8'h00, 1'b0));
		send(mk(OP_SHRI, 8'd2,   8'd0,   16'd16,   8'h00, 1'b0));
		send(mk(OP_SHLI, 8'd1,   8'd0,   16'hFFFF, 8'h00, 1'b0));
		// Decrement-and-branch: to zero without a branch, then wrapping and taken.
		send(mk(OP_MOVI, 8'd3,   8'd0,   16'h0001, 8'h00, 1'b0));
		send(mk(OP_JNZ,  8'd3,   8'd0,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_JNZ,  8'd3,   8'd0,   16'h0000, 8'h00, 1'b0));
		// Signed compares against the immediate and a variable, and the never codes.
		send(mk(OP_CJMP, 8'd255, 8'd0,   16'h8000, {5'd0, COND_EQ}, 1'b0));
		send(mk(OP_CJMP, 8'd255, 8'd3,   16'h0000, {5'h10, COND_GT}, 1'b0));
		send(mk(OP_CJMP, 8'd255, 8'd3,   16'h0000, {5'h10, COND_LT}, 1'b0));
		send(mk(OP_CJMP, 8'd3,   8'd3,   16'hFFFF, 8'h06, 1'b0));
		send(mk(OP_CJMP, 8'd3,   8'd3,   16'hFFFF, 8'hFF, 1'b0));
		// Stack: return on an empty stack, then a call and its return.
		send(mk(OP_RET,  8'd0,   8'd0,   16'h0000, 8'h00, 1'b1));
		send(mk(OP_CALL, 8'd0,   8'd0,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_RET,  8'd0,   8'd0,   16'h0000, 8'h00, 1'b0));
		// Yield, jump, kill and unsupported opcodes.
		send(mk(OP_YLD,  8'd0,   8'd0,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_JMP,  8'd0,   8'd0,   16'h0000, 8'h00, 1'b0));
		send(mk(OP_KILL, 8'd0,   8'd0,   16'h0000, 8'h00, 1'b0));
		send(mk(8'h08,   8'hFF,  8'hFF,  16'hFFFF, 8'hFF, 1'b0));
		send(mk(8'hFF,   8'hFF,  8'hFF,  16'hFFFF, 8'hFF, 1'b1));

		// Fill the stack past its depth once before the mixed stream.
		call_chain(RET_DEPTH + 2, 1'b1);

		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				no_idle = !no_idle;
			r = $urandom_range(0, 99);
			if (r < 2)
				call_chain(RET_DEPTH + 2, 1'b1);
			else if (r < 30)
				call_chain($urandom_range(1, 8), $urandom_range(0, 3) == 0);
			else
				repeat ($urandom_range(1, 10)) send(rand_item());
		end
		instr_bus.valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d instructions, %0d results compared, return stack reached depth %0d.",
			sent, sb.checked, sb.max_level);
		$display("Fault cases: %0d overflows, %0d underflows, %0d unsupported opcodes.",
			sb.overflows, sb.underflows, sb.bad_opcodes);
		if (sb.mismatches == 0) begin
			$display("[script_vm_execute_core] OK");
		end else begin
			$display("%0d results failed the check.", sb.mismatches);
			$display("[script_vm_execute_core] ERROR");
		end
		$finish;
	end

endmodule
